@@ rtl/b64d_pkg.sv @@
// Shared types, constants and the character decode for the Base64 decoder.
// No dependencies; every other file of the block refers to it by scoped names.
package b64d_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] CharPlus  = 8'h2b;
  localparam logic [7:0] CharSlash = 8'h2f;

  // One decoded group handed from the front to the back: the bytes sit in
  // the top of the group and nbytes (1 to 3) says how many are used.
  typedef struct packed {
    logic [23:0] group;
    logic [1:0]  nbytes;
  } entry_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } sextet_t;

  function automatic sextet_t sextet_of(logic [7:0] c);
    sextet_t s;
    s.valid = 1'b1;
    s.value = 6'd0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      s.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      s.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == CharPlus) begin
      s.value = 6'd62;
    end else if (c == CharSlash) begin
      s.value = 6'd63;
    end else begin
      s.valid = 1'b0;
    end
    return s;
  endfunction

endpackage

@@ rtl/b64d_front.sv @@
// Front end of the Base64 decoder: classifies each character, collects
// sextets and pushes finished or flushed groups. Depends on b64d_pkg.
module b64d_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [7:0]        char_in_i,
  input  logic              message_end_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output b64d_pkg::entry_t  q_data_o
);

  logic [17:0]       store_q, store_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              halted_q, halted_d;
  logic              accept;
  b64d_pkg::sextet_t sx;
  logic [17:0]       fl_store;
  logic [1:0]        fl_cnt;
  logic              do_flush;

  assign accept = push_i && !q_full_i;
  assign sx     = b64d_pkg::sextet_of(char_in_i);

  always_comb begin
    store_d         = store_q;
    cnt_d           = cnt_q;
    halted_d        = halted_q;
    q_push_o        = 1'b0;
    q_data_o.group  = 24'd0;
    q_data_o.nbytes = 2'd0;
    fl_store        = store_q;
    fl_cnt          = cnt_q;
    do_flush        = 1'b0;
    if (accept) begin
      if (halted_q) begin
        if (message_end_i) begin
          halted_d = 1'b0;
        end
      end else if (sx.valid) begin
        if (cnt_q == 2'd3) begin
          q_push_o        = 1'b1;
          q_data_o.group  = {store_q, sx.value};
          q_data_o.nbytes = 2'd3;
          fl_store        = 18'd0;
          fl_cnt          = 2'd0;
        end else begin
          fl_store = {store_q[11:0], sx.value};
          fl_cnt   = cnt_q + 2'd1;
        end
        store_d  = fl_store;
        cnt_d    = fl_cnt;
        do_flush = message_end_i;
      end else begin
        do_flush = 1'b1;
        halted_d = !message_end_i;
      end

      // A full group and a flush can coincide, but the group leaves nothing pending.
      if (do_flush) begin
        store_d = 18'd0;
        cnt_d   = 2'd0;
        if (fl_cnt == 2'd2) begin
          q_push_o        = 1'b1;
          q_data_o.group  = {fl_store[11:0], 12'd0};
          q_data_o.nbytes = 2'd1;
        end else if (fl_cnt == 2'd3) begin
          q_push_o        = 1'b1;
          q_data_o.group  = {fl_store, 6'd0};
          q_data_o.nbytes = 2'd2;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q  <= 18'd0;
      cnt_q    <= 2'd0;
      halted_q <= 1'b0;
    end else begin
      store_q  <= store_d;
      cnt_q    <= cnt_d;
      halted_q <= halted_d;
    end
  end

  // A stop always flushes, so nothing stays pending while halted.
  assert property (@(posedge clk_i) disable iff (!rst_ni) halted_q |-> cnt_q == 2'd0)
    else $error("b64d_front: sextets pending while halted");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> store_q == 18'd0)
    else $error("b64d_front: stale sextet bits with an empty group");

endmodule

@@ rtl/b64d_queue.sv @@
// Short first-in first-out queue of decoded groups between front and back.
// Depends on b64d_pkg for the entry type.
module b64d_queue #(
  parameter int unsigned Depth = b64d_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  b64d_pkg::entry_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output b64d_pkg::entry_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64d_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o  = count_q == CntW'(Depth);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(Depth))
    else $error("b64d_queue: occupancy beyond depth");

endmodule

@@ rtl/b64d_back.sv @@
// Back end of the Base64 decoder: takes groups from the queue and hands
// them out one byte per transaction. Depends on b64d_pkg.
module b64d_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  b64d_pkg::entry_t q_data_i,
  output logic             q_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [7:0]       byte_out_o,
  output logic             run_last_o
);

  logic        valid_q, valid_d;
  logic [23:0] group_q;
  logic [1:0]  n_q;
  logic [1:0]  idx_q, idx_d;
  logic        last_byte;
  logic        load;

  assign last_byte  = idx_q == (n_q - 2'd1);
  assign empty_o    = !valid_q;
  assign run_last_o = last_byte;
  assign load       = !q_empty_i && (!valid_q || (pop_i && last_byte));
  assign q_pop_o    = load;

  always_comb begin
    case (idx_q)
      2'd0:    byte_out_o = group_q[23:16];
      2'd1:    byte_out_o = group_q[15:8];
      default: byte_out_o = group_q[7:0];
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (valid_q && pop_i) begin
      if (last_byte) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
    if (load) begin
      valid_d = 1'b1;
      idx_d   = 2'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      group_q <= q_data_i.group;
      n_q     <= q_data_i.nbytes;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  // Within a group the next byte follows without a gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && pop_i && !last_byte) |=> valid_q)
    else $error("b64d_back: gap inside a decoded group");

endmodule

@@ rtl/base64_decoder.sv @@
// Streaming Base64 decoder, top level. Instantiates b64d_front, b64d_queue
// and b64d_back; depends on b64d_pkg.
//
// Usage: characters enter through a queue-like port. A character and its
// message_end_i flag are taken at a rising edge where push is high and
// full is low. Decoded bytes leave through a second queue-like port: while
// empty is low the oldest byte is on byte_out_o, with run_last_o marking
// the last byte that one character caused, and it is taken at an edge where
// pop is high.
// Path: the group that a character completes is written into the queue when
// that character is taken and is then loaded into the output stage for pop.
// Throughput: one character per cycle while full is low, one byte per cycle
// while empty is low. Every four characters give three bytes, so the byte
// side keeps up. The front classifies and packs each sextet when taken; a
// queue of QueueDepth groups sits between it and the byte serializer.
// When the receiver stalls, the serializer holds its byte, the queue fills
// and full then holds off further characters; nothing is lost.
// Reset clears the pending sextets, the stop state, the queue and the
// output stage; the block takes characters as soon as reset is released.
module base64_decoder #(
  parameter int unsigned QueueDepth = b64d_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_in_i,
  input  logic       message_end_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] byte_out_o,
  output logic       run_last_o
);

  logic             q_push, q_full, q_pop, q_empty;
  b64d_pkg::entry_t q_wdata, q_rdata;

  assign full = q_full;

  b64d_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .char_in_i     (char_in_i),
    .message_end_i (message_end_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata)
  );

  b64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  b64d_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .byte_out_o (byte_out_o),
    .run_last_o (run_last_o)
  );

endmodule
